/* hdl/ebcpu_alu_pkg.sv */
package ebcpu_alu_pkg;

  // Register file geometry.
  localparam int REG_COUNT  = 8;
  localparam int REG_IDX_W  = 3;
  localparam int ADDR_SPACE = 1 << REG_IDX_W;
  localparam int BANK_DEPTH = ADDR_SPACE / 2;
  localparam int BANK_AW    = REG_IDX_W - 1;

  // Flag bit positions inside the 4-bit flag word.
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_ADD16   = 4'd2,
    OP_DAA     = 4'd3,
    OP_RLA     = 4'd4,
    OP_RL      = 4'd5,
    OP_RRA     = 4'd6,
    OP_RR      = 4'd7,
    OP_SLA     = 4'd8,
    OP_SRA     = 4'd9,
    OP_SRL     = 4'd10,
    OP_LOAD    = 4'd11
  } alu_op_t;

  typedef struct packed {
    logic [3:0]           req_type;
    logic                 with_carry;
    logic [REG_IDX_W-1:0] reg_index;
    logic [15:0]          operand_value;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [3:0]  flag_bits;
  } alu_rsp_t;

  // True when the index names a register that exists in the file.
  function automatic logic idx_in_range(input logic [REG_IDX_W-1:0] idx);
    return (32'(idx) < REG_COUNT);
  endfunction

endpackage

/* hdl/eight_bit_cpu_alu_with_flags_top.sv */
// Eight-bit CPU ALU with a Z/N/H/C flag register.
// Requests arrive on req (valid/ready) and each one runs a single ALU operation
// on the register file: add/adc, sub/sbc, a 16-bit register-pair add, decimal
// adjust, rotates, shifts, or a plain register load. Every request yields one
// response on rsp (valid/ready) with the new register value and the new flags.
// The register file lives in two synchronous RAM banks (even and odd indexes),
// so a pair add reads and writes both halves of a pair in one access.
// An accepted request is read from the banks into the compute stage, and its
// result goes into the output register. Throughput: one request per cycle
// while rsp moves; the next request's bank read overlaps the compute and
// write-back of the current one, with a one-entry bypass for a same-row write.
// When the receiver stalls, the response waits in the output register and one
// more request is held in the compute stage; req_ready then drops until rsp
// moves again. Reset (rst, synchronous) clears the flags, marks every register
// as zero through per-entry valid bits, and empties the pipeline; the block
// accepts requests in the first cycle after reset.
module eight_bit_cpu_alu_with_flags_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  ebcpu_alu_pkg::alu_req_t req,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output ebcpu_alu_pkg::alu_rsp_t rsp
);

  localparam int AW = ebcpu_alu_pkg::BANK_AW;
  localparam int REG_IDX_TOP = ebcpu_alu_pkg::REG_IDX_W - 1;

  logic [7:0] mem_even [ebcpu_alu_pkg::BANK_DEPTH];
  logic [7:0] mem_odd  [ebcpu_alu_pkg::BANK_DEPTH];
  logic [ebcpu_alu_pkg::BANK_DEPTH-1:0] vld_even;
  logic [ebcpu_alu_pkg::BANK_DEPTH-1:0] vld_odd;

  logic                    req_fire;
  logic                    s1_valid;
  logic                    s1_fire;
  ebcpu_alu_pkg::alu_req_t s1_req;
  logic [3:0]              flag_q;

  logic [7:0] rd_even, rd_odd;
  logic       rd_vld_even, rd_vld_odd;
  logic       byp_hit_even, byp_hit_odd;
  logic [7:0] byp_data_even, byp_data_odd;

  logic [AW-1:0] wr_addr;
  logic          we_even, we_odd;
  logic [7:0]    wd_even, wd_odd;
  logic [15:0]   res;
  logic [3:0]    flag_next;

  assign s1_fire   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_fire;
  assign req_fire  = req_valid && req_ready;
  assign wr_addr   = s1_req.reg_index[REG_IDX_TOP:1];

  // Bank read on acceptance, plus a capture of any write landing on the same
  // row in that cycle, since the RAM returns the old contents.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rd_even       <= mem_even[req.reg_index[REG_IDX_TOP:1]];
      rd_odd        <= mem_odd[req.reg_index[REG_IDX_TOP:1]];
      rd_vld_even   <= vld_even[req.reg_index[REG_IDX_TOP:1]];
      rd_vld_odd    <= vld_odd[req.reg_index[REG_IDX_TOP:1]];
      byp_hit_even  <= we_even && (wr_addr == req.reg_index[REG_IDX_TOP:1]);
      byp_hit_odd   <= we_odd && (wr_addr == req.reg_index[REG_IDX_TOP:1]);
      byp_data_even <= wd_even;
      byp_data_odd  <= wd_odd;
      s1_req        <= req;
    end
    if (we_even) begin
      mem_even[wr_addr] <= wd_even;
    end
    if (we_odd) begin
      mem_odd[wr_addr] <= wd_odd;
    end
    if (s1_fire) begin
      rsp.result_value <= res;
      rsp.flag_bits    <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      flag_q    <= '0;
      vld_even  <= '0;
      vld_odd   <= '0;
    end else begin
      if (req_ready) begin
        s1_valid <= req_valid;
      end
      if (s1_fire) begin
        rsp_valid <= 1'b1;
        flag_q    <= flag_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (we_even) begin
        vld_even[wr_addr] <= 1'b1;
      end
      if (we_odd) begin
        vld_odd[wr_addr] <= 1'b1;
      end
    end
  end

  // Compute and write-back stage.
  always_comb begin
    logic [REG_IDX_TOP:0] idx, idx_hi, idx_lo;
    logic [7:0]  even_b, odd_b, a, b, r8, hi_b, lo_b;
    logic [8:0]  s9;
    logic [4:0]  h5;
    logic [15:0] pair;
    logic [16:0] s17;
    logic [12:0] h13;
    logic        cin, c, wr8, wc;

    idx    = s1_req.reg_index;
    idx_hi = {idx[REG_IDX_TOP:1], 1'b0};
    idx_lo = {idx[REG_IDX_TOP:1], 1'b1};
    wc     = s1_req.with_carry;
    even_b = byp_hit_even ? byp_data_even : (rd_vld_even ? rd_even : 8'h00);
    odd_b  = byp_hit_odd ? byp_data_odd : (rd_vld_odd ? rd_odd : 8'h00);
    a      = ebcpu_alu_pkg::idx_in_range(idx) ? (idx[0] ? odd_b : even_b) : 8'h00;
    b      = s1_req.operand_value[7:0];
    hi_b   = ebcpu_alu_pkg::idx_in_range(idx_hi) ? even_b : 8'h00;
    lo_b   = ebcpu_alu_pkg::idx_in_range(idx_lo) ? odd_b : 8'h00;
    pair   = {hi_b, lo_b};
    cin    = flag_q[ebcpu_alu_pkg::FLAG_C];
    c      = 1'b0;
    s9     = '0;
    h5     = '0;
    s17    = '0;
    h13    = '0;
    r8     = 8'h00;
    wr8    = 1'b0;
    res    = '0;
    flag_next = flag_q;
    we_even = 1'b0;
    we_odd  = 1'b0;
    wd_even = 8'h00;
    wd_odd  = 8'h00;

    unique case (ebcpu_alu_pkg::alu_op_t'(s1_req.req_type))
      ebcpu_alu_pkg::OP_ADD: begin
        c   = wc & cin;
        s9  = {1'b0, a} + {1'b0, b} + {8'h00, c};
        h5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, c};
        r8  = s9[7:0];
        wr8 = 1'b1;
        flag_next = {r8 == 8'h00, 1'b0, h5[4], s9[8]};
      end
      ebcpu_alu_pkg::OP_SUB: begin
        c   = wc & cin;
        s9  = {1'b0, a} - {1'b0, b} - {8'h00, c};
        h5  = {1'b0, b[3:0]} + {4'h0, c};
        r8  = s9[7:0];
        wr8 = 1'b1;
        flag_next = {r8 == 8'h00, 1'b1, {1'b0, a[3:0]} < h5,
                     {1'b0, a} < ({1'b0, b} + {8'h00, c})};
      end
      ebcpu_alu_pkg::OP_ADD16: begin
        s17 = {1'b0, pair} + {1'b0, s1_req.operand_value};
        h13 = {1'b0, pair[11:0]} + {1'b0, s1_req.operand_value[11:0]};
        res = s17[15:0];
        flag_next = {flag_q[ebcpu_alu_pkg::FLAG_Z], 1'b0, h13[12], s17[16]};
        we_even = s1_fire && ebcpu_alu_pkg::idx_in_range(idx_hi);
        we_odd  = s1_fire && ebcpu_alu_pkg::idx_in_range(idx_lo);
        wd_even = s17[15:8];
        wd_odd  = s17[7:0];
      end
      ebcpu_alu_pkg::OP_DAA: begin
        c  = cin;
        r8 = a;
        if (!flag_q[ebcpu_alu_pkg::FLAG_N]) begin
          if (c || (a > 8'h99)) begin
            r8 = r8 + 8'h60;
            c  = 1'b1;
          end
          if (flag_q[ebcpu_alu_pkg::FLAG_H] || (a[3:0] > 4'd9)) begin
            r8 = r8 + 8'h06;
          end
        end else begin
          if (c) begin
            r8 = r8 - 8'h60;
          end
          if (flag_q[ebcpu_alu_pkg::FLAG_H]) begin
            r8 = r8 - 8'h06;
          end
        end
        wr8 = 1'b1;
        flag_next = {r8 == 8'h00, flag_q[ebcpu_alu_pkg::FLAG_N], 1'b0, c};
      end
      ebcpu_alu_pkg::OP_RLA, ebcpu_alu_pkg::OP_RL: begin
        r8  = {a[6:0], wc ? a[7] : cin};
        wr8 = 1'b1;
        // The accumulator form always clears Z.
        flag_next = {(s1_req.req_type == ebcpu_alu_pkg::OP_RL) && (r8 == 8'h00),
                     2'b00, a[7]};
      end
      ebcpu_alu_pkg::OP_RRA, ebcpu_alu_pkg::OP_RR: begin
        r8  = {wc ? a[0] : cin, a[7:1]};
        wr8 = 1'b1;
        flag_next = {(s1_req.req_type == ebcpu_alu_pkg::OP_RR) && (r8 == 8'h00),
                     2'b00, a[0]};
      end
      ebcpu_alu_pkg::OP_SLA: begin
        r8  = {a[6:0], 1'b0};
        wr8 = 1'b1;
        flag_next = {r8 == 8'h00, 2'b00, a[7]};
      end
      ebcpu_alu_pkg::OP_SRA: begin
        r8  = {a[7], a[7:1]};
        wr8 = 1'b1;
        flag_next = {r8 == 8'h00, 2'b00, a[0]};
      end
      ebcpu_alu_pkg::OP_SRL: begin
        r8  = {1'b0, a[7:1]};
        wr8 = 1'b1;
        flag_next = {r8 == 8'h00, 2'b00, a[0]};
      end
      ebcpu_alu_pkg::OP_LOAD: begin
        r8  = b;
        wr8 = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase

    if (wr8) begin
      res = {8'h00, r8};
      if (idx[0]) begin
        we_odd = s1_fire && ebcpu_alu_pkg::idx_in_range(idx);
        wd_odd = r8;
      end else begin
        we_even = s1_fire && ebcpu_alu_pkg::idx_in_range(idx);
        wd_even = r8;
      end
    end
  end

  // A request held in the compute stage keeps its operands.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_req))
    else $error("compute stage lost or changed a held request");

  // Flags move only when a request completes its compute stage.
  a_flag_quiet: assert property (@(posedge clk) disable iff (rst)
    !s1_fire |=> $stable(flag_q))
    else $error("flag register changed without a completing request");

  // An even bank write marks its entry as written.
  a_vld_set: assert property (@(posedge clk) disable iff (rst)
    we_even |=> vld_even[$past(wr_addr)])
    else $error("even bank write did not set its valid bit");

  // Bank writes happen only for a completing request.
  a_we_fire: assert property (@(posedge clk) disable iff (rst)
    (we_even || we_odd) |-> s1_fire)
    else $error("bank write without a completing request");

endmodule
